// File: hw/rtl/alu16fc_pkg.sv
// Package for the 16-bit ALU with flag register: item types, opcodes,
// flag bit positions and condition codes. No dependencies.
`timescale 1ns / 1ps

package alu16fc_pkg;

    localparam int WORD_W = 16;
    localparam int FLAG_W = 4;

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_ADC     = 4'd1;
    localparam logic [3:0] OP_SUB     = 4'd2;
    localparam logic [3:0] OP_SBB     = 4'd3;
    localparam logic [3:0] OP_MULH_UU = 4'd4;
    localparam logic [3:0] OP_MULH_SS = 4'd5;
    localparam logic [3:0] OP_MULH_US = 4'd6;
    localparam logic [3:0] OP_MUL_LO  = 4'd7;
    localparam logic [3:0] OP_SHL     = 4'd8;
    localparam logic [3:0] OP_SHR     = 4'd9;
    localparam logic [3:0] OP_AND     = 4'd10;
    localparam logic [3:0] OP_OR      = 4'd11;
    localparam logic [3:0] OP_XOR     = 4'd12;

    localparam int FLAG_Z = 0;
    localparam int FLAG_S = 1;
    localparam int FLAG_C = 2;
    localparam int FLAG_O = 3;

    localparam logic [2:0] COND_TRUE  = 3'd0;
    localparam logic [2:0] COND_CZ    = 3'd1;
    localparam logic [2:0] COND_LT    = 3'd2;
    localparam logic [2:0] COND_LE    = 3'd3;
    localparam logic [2:0] COND_S     = 3'd4;
    localparam logic [2:0] COND_Z     = 3'd5;
    localparam logic [2:0] COND_O     = 3'd6;
    localparam logic [2:0] COND_C     = 3'd7;

    localparam logic [FLAG_W-1:0] FLAGS_CLEAR = 4'b0000;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic              carry_in;
        logic              update_flags;
        logic [3:0]        cond_select;
    } alu16fc_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic [FLAG_W-1:0] flags_out;
        logic              cond_true;
    } alu16fc_out_t;

endpackage

// File: hw/rtl/alu16fc_exec.sv
// Combinational execute stage: adder, multiplier, shifter, logic unit,
// flag update and condition evaluation. Depends on alu16fc_pkg.
`timescale 1ns / 1ps

module alu16fc_exec (
    input  alu16fc_pkg::alu16fc_in_t        item_in,
    input  logic [alu16fc_pkg::FLAG_W-1:0]  flags_cur,
    output alu16fc_pkg::alu16fc_out_t       item_out
);

    logic [15:0]        a;
    logic [15:0]        b;
    logic               is_sub;
    logic [15:0]        b_add;
    logic               cin;
    logic [16:0]        sum;
    logic [15:0]        sum_r;
    logic               add_c;
    logic               add_o;
    logic               a_signed;
    logic               b_signed;
    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] prod;
    logic [15:0]        r;
    logic [3:0]         f;
    logic               z;
    logic               s;
    logic               c;
    logic               o;
    logic               v;

    assign a        = item_in.operand_a;
    assign b        = item_in.operand_b;
    assign is_sub   = (item_in.opcode == alu16fc_pkg::OP_SUB) ||
                      (item_in.opcode == alu16fc_pkg::OP_SBB);
    assign b_add    = is_sub ? ~b : b;
    assign sum      = {1'b0, a} + {1'b0, b_add} + {16'd0, cin};
    assign sum_r    = sum[15:0];
    assign add_c    = sum[16] ^ is_sub;
    assign add_o    = (a[15] == b_add[15]) && (sum_r[15] != a[15]);

    assign a_signed = (item_in.opcode == alu16fc_pkg::OP_MULH_SS);
    assign b_signed = (item_in.opcode == alu16fc_pkg::OP_MULH_SS) ||
                      (item_in.opcode == alu16fc_pkg::OP_MULH_US);
    assign mul_a    = $signed({a_signed & a[15], a});
    assign mul_b    = $signed({b_signed & b[15], b});
    assign prod     = mul_a * mul_b;

    always_comb begin
        case (item_in.opcode)
            alu16fc_pkg::OP_ADC: cin = item_in.carry_in;
            alu16fc_pkg::OP_SUB: cin = 1'b1;
            alu16fc_pkg::OP_SBB: cin = ~item_in.carry_in;
            default:             cin = 1'b0;
        endcase
    end

    always_comb begin
        r = 16'd0;
        f = flags_cur;
        case (item_in.opcode)
            alu16fc_pkg::OP_ADD, alu16fc_pkg::OP_ADC,
            alu16fc_pkg::OP_SUB, alu16fc_pkg::OP_SBB: begin
                r = sum_r;
                if (item_in.update_flags) begin
                    f[alu16fc_pkg::FLAG_Z] = (sum_r == 16'd0);
                    f[alu16fc_pkg::FLAG_S] = sum_r[15];
                    f[alu16fc_pkg::FLAG_C] = add_c;
                    f[alu16fc_pkg::FLAG_O] = add_o;
                end
            end
            alu16fc_pkg::OP_MULH_UU, alu16fc_pkg::OP_MULH_SS,
            alu16fc_pkg::OP_MULH_US: begin
                r = prod[31:16];
            end
            alu16fc_pkg::OP_MUL_LO: begin
                r = prod[15:0];
            end
            alu16fc_pkg::OP_SHL, alu16fc_pkg::OP_SHR: begin
                r = (item_in.opcode == alu16fc_pkg::OP_SHL) ? (a << b[3:0]) : (a >> b[3:0]);
                if (item_in.update_flags) begin
                    f[alu16fc_pkg::FLAG_Z] = (r == 16'd0);
                    f[alu16fc_pkg::FLAG_S] = r[15];
                end
            end
            alu16fc_pkg::OP_AND, alu16fc_pkg::OP_OR, alu16fc_pkg::OP_XOR: begin
                if (item_in.opcode == alu16fc_pkg::OP_AND) begin
                    r = a & b;
                end else if (item_in.opcode == alu16fc_pkg::OP_OR) begin
                    r = a | b;
                end else begin
                    r = a ^ b;
                end
                if (item_in.update_flags) begin
                    f[alu16fc_pkg::FLAG_Z] = (r == 16'd0);
                    f[alu16fc_pkg::FLAG_S] = r[15];
                    f[alu16fc_pkg::FLAG_C] = 1'b0;
                end
            end
            default: begin
                r = 16'd0;
            end
        endcase
    end

    assign z = f[alu16fc_pkg::FLAG_Z];
    assign s = f[alu16fc_pkg::FLAG_S];
    assign c = f[alu16fc_pkg::FLAG_C];
    assign o = f[alu16fc_pkg::FLAG_O];

    always_comb begin
        case (item_in.cond_select[2:0])
            alu16fc_pkg::COND_TRUE: v = 1'b1;
            alu16fc_pkg::COND_CZ:   v = c | z;
            alu16fc_pkg::COND_LT:   v = s ^ o;
            alu16fc_pkg::COND_LE:   v = z | (s ^ o);
            alu16fc_pkg::COND_S:    v = s;
            alu16fc_pkg::COND_Z:    v = z;
            alu16fc_pkg::COND_O:    v = o;
            alu16fc_pkg::COND_C:    v = c;
            default:                v = 1'b1;
        endcase
    end

    assign item_out.result    = r;
    assign item_out.flags_out = f;
    assign item_out.cond_true = v ^ item_in.cond_select[3];

endmodule

// File: hw/rtl/alu16_flags_conditions_core.sv
// Top level of the 16-bit ALU: input register, execute stage, result
// register and flag register. Depends on alu16fc_pkg and alu16fc_exec.
`timescale 1ns / 1ps

// Accepts one item per cycle on s_valid/s_ready while m_ready does not stall
// the result register, and returns one result per item on m_valid/m_ready, in
// order. An item is held in the input register and moves to the result
// register when that register is empty or being read; from there it is shown
// on m_valid. The rate is set by the loop from the flag register through the
// adder, shifter or logic unit and back, and by the single 17x17 multiplier,
// all in one pass. The flag register resets to all clear and is written as
// each item moves into the result register.
module alu16_flags_conditions_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  alu16fc_pkg::alu16fc_in_t    s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output alu16fc_pkg::alu16fc_out_t   m_data
);

    logic                              in_valid_reg;
    alu16fc_pkg::alu16fc_in_t          in_data_reg;
    logic                              out_valid_reg;
    alu16fc_pkg::alu16fc_out_t         out_data_reg;
    logic [alu16fc_pkg::FLAG_W-1:0]    flags_reg;
    alu16fc_pkg::alu16fc_out_t         exec_out;
    logic                              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    alu16fc_exec u_exec (
        .item_in   (in_data_reg),
        .flags_cur (flags_reg),
        .item_out  (exec_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= alu16fc_pkg::FLAGS_CLEAR;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= exec_out.flags_out;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= exec_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
